// ===== design/s2c_pkg.sv =====
// shared types and constants of the spherical to cartesian normalizer
// no dependencies; used by the normalizer unit, s2c_cordic and s2c_gain
package s2c_pkg;

    localparam int GUARD_BITS = 8;
    localparam int ATAN_ENTRIES = 40;
    localparam logic [30:0] INV_GAIN = 31'h4DBA76D4;

    typedef struct packed {
        logic signed [31:0] range_in;
        logic signed [31:0] bearing_in;
        logic signed [31:0] elevation_in;
    } polar_beat_t;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
        logic [30:0]        range_out;
        logic signed [31:0] bearing_out;
        logic signed [31:0] elevation_out;
    } cart_beat_t;

    // arctangent of 2^-i, full turn = 2^32
    function automatic logic [31:0] atan_entry(input logic [5:0] idx);
        logic [31:0] a;
        case (idx)
            6'd0:    a = 32'h20000000;
            6'd1:    a = 32'h12E4051E;
            6'd2:    a = 32'h09FB385B;
            6'd3:    a = 32'h051111D4;
            6'd4:    a = 32'h028B0D43;
            6'd5:    a = 32'h0145D7E1;
            6'd6:    a = 32'h00A2F61E;
            6'd7:    a = 32'h00517C55;
            6'd8:    a = 32'h0028BE53;
            6'd9:    a = 32'h00145F2F;
            6'd10:   a = 32'h000A2F98;
            6'd11:   a = 32'h000517CC;
            6'd12:   a = 32'h00028BE6;
            6'd13:   a = 32'h000145F3;
            6'd14:   a = 32'h0000A2FA;
            6'd15:   a = 32'h0000517D;
            6'd16:   a = 32'h000028BE;
            6'd17:   a = 32'h0000145F;
            6'd18:   a = 32'h00000A30;
            6'd19:   a = 32'h00000518;
            6'd20:   a = 32'h0000028C;
            6'd21:   a = 32'h00000146;
            6'd22:   a = 32'h000000A3;
            6'd23:   a = 32'h00000051;
            6'd24:   a = 32'h00000029;
            6'd25:   a = 32'h00000014;
            6'd26:   a = 32'h0000000A;
            6'd27:   a = 32'h00000005;
            6'd28:   a = 32'h00000003;
            6'd29:   a = 32'h00000001;
            6'd30:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ===== design/s2c_stream_if.sv =====
// valid/ready stream channel carrying one payload beat
// payload type comes from s2c_pkg at the instantiation
interface s2c_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/spherical_to_cartesian_normalizer_unit.sv =====
// Spherical to cartesian normalizer. Takes one polar point per beat, folds the
// angles into bearing [-pi, pi) and elevation [-pi/2, pi/2], makes the range
// nonnegative, and returns x, y, z with the normalized triple. Fully pipelined:
// a new point is taken every cycle while the output is not stalled; the stages
// are normalize, gain multiply, gain round, elevation rotation, two-stage gain
// rescale, bearing rotation, output rounding. A stall at the output freezes
// the whole pipe. Depends on s2c_pkg, s2c_stream_if, s2c_cordic, s2c_gain.
module spherical_to_cartesian_normalizer_unit #(
    parameter int ANGLE_BITS = 32,
    parameter int RANGE_BITS = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    s2c_stream_if.sink   polar,
    s2c_stream_if.source cart
);

    localparam int A = ANGLE_BITS;
    localparam int G = s2c_pkg::GUARD_BITS;
    localparam int P = (RANGE_BITS < 32) ? RANGE_BITS : 32;
    localparam int MW = P - 1;
    localparam int NST = (CORDIC_STAGES > s2c_pkg::ATAN_ENTRIES) ?
                         s2c_pkg::ATAN_ENTRIES : CORDIC_STAGES;
    localparam int DW = P + G + 2;
    localparam int ZW = 34;
    localparam int PW = MW + 31;
    localparam logic [A-1:0] ANG_Q = A'(1) << (A - 2);
    localparam logic [A-1:0] ANG_H = A'(1) << (A - 1);
    localparam logic [A-1:0] ANG_3Q = A'(3) << (A - 2);
    localparam logic signed [32:0] RMAX = 33'((64'sd1 <<< (P - 1)) - 64'sd1);
    localparam logic signed [32:0] RMIN = -RMAX - 33'sd1;
    localparam logic signed [DW:0] OMAX = (DW+1)'((64'sd1 <<< (P - 1)) - 64'sd1);
    localparam logic signed [DW:0] OMIN = -OMAX - (DW+1)'(1);
    localparam int S1W = MW + 64;
    localparam int S2W = S1W + DW + ZW;
    localparam int S3W = S1W + DW;

    logic en;
    assign en = !cart.valid || cart.ready;
    assign polar.ready = en;

    // ---- stage 0: normalization ----
    logic [A-1:0] b_w, e_w, e1, b1, e_neg, e2, b2, b_fin, e_fin;
    logic         flip1, flip2, neg;
    logic signed [32:0] rx, rc, rmag;
    logic [31:0]  b32_n, e32_n;
    logic [MW-1:0] m_n;

    if (A >= 32) begin : g_wide
        assign b_w = A'(polar.data.bearing_in) << (A - 32);
        assign e_w = A'(polar.data.elevation_in) << (A - 32);
        assign b32_n = b_fin[A-1 -: 32];
        assign e32_n = e_fin[A-1 -: 32];
    end else begin : g_narrow
        assign b_w = polar.data.bearing_in[31 -: A];
        assign e_w = polar.data.elevation_in[31 -: A];
        assign b32_n = 32'(b_fin) << (32 - A);
        assign e32_n = 32'(e_fin) << (32 - A);
    end

    always_comb
    begin
        flip1 = (e_w >= ANG_Q) && (e_w < ANG_3Q);
        e1 = flip1 ? ANG_H - e_w : e_w;
        b1 = flip1 ? b_w + ANG_H : b_w;
        rx = {polar.data.range_in[31], polar.data.range_in};
        if (rx > RMAX)
            rc = RMAX;
        else if (rx < RMIN)
            rc = RMIN;
        else
            rc = rx;
        neg = rc[32];
        rmag = neg ? -rc : rc;
        if (rmag > RMAX)
            rmag = RMAX;
        m_n = rmag[MW-1:0];
        // negative range: negate both angles and fold again
        e_neg = -e1;
        flip2 = (e_neg >= ANG_Q) && (e_neg < ANG_3Q);
        e2 = flip2 ? ANG_H - e_neg : e_neg;
        b2 = flip2 ? ANG_H - b1 : -b1;
        b_fin = neg ? b2 : b1;
        e_fin = neg ? e2 : e1;
    end

    logic          v0_reg, v1_reg, v2_reg;
    logic [MW-1:0] m0_reg, m1_reg, m2_reg;
    logic [31:0]   b0_reg, e0_reg, b1_reg, e1_reg, b2_reg, e2_reg;
    logic [PW-1:0] prod_reg;
    logic signed [DW-1:0] x0_reg;
    logic [PW:0]   prod_rnd;

    assign prod_rnd = (PW+1)'(prod_reg) + ((PW+1)'(1) << (30 - G));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= polar.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg   <= m_n;
            b0_reg   <= b32_n;
            e0_reg   <= e32_n;
            prod_reg <= PW'(m0_reg) * PW'(s2c_pkg::INV_GAIN);
            m1_reg   <= m0_reg;
            b1_reg   <= b0_reg;
            e1_reg   <= e0_reg;
            x0_reg   <= DW'(prod_rnd >> (31 - G));
            m2_reg   <= m1_reg;
            b2_reg   <= b1_reg;
            e2_reg   <= e1_reg;
        end
    end

    // ---- elevation rotation ----
    logic                 c1_valid;
    logic signed [DW-1:0] c1_x, c1_y;
    logic [S1W-1:0]       c1_side;

    s2c_cordic #(.DW(DW), .ZW(ZW), .NST(NST), .SW(S1W)) u_rot_elev (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v2_reg),
        .in_x(x0_reg),
        .in_y('0),
        .in_z(ZW'($signed(e2_reg))),
        .in_side({m2_reg, b2_reg, e2_reg}),
        .out_valid(c1_valid), .out_x(c1_x), .out_y(c1_y), .out_side(c1_side)
    );

    // bearing beyond +-pi/2: rotate by the reduced angle from a negated start
    logic signed [31:0]   c1_b;
    logic                 bflip;
    logic signed [ZW-1:0] z2;

    assign c1_b = $signed(c1_side[63:32]);
    assign bflip = (c1_b > 32'sh40000000) || (c1_b < -32'sh40000000);
    always_comb
    begin
        if (!bflip)
            z2 = ZW'(c1_b);
        else if (c1_b[31])
            z2 = ZW'(c1_b) + (ZW'(1) << 31);
        else
            z2 = ZW'(c1_b) - (ZW'(1) << 31);
    end

    logic                 g_valid;
    logic signed [DW-1:0] g_x;
    logic [S2W-1:0]       g_side;

    s2c_gain #(.DW(DW), .SW(S2W)) u_gain (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(c1_valid),
        .in_x(c1_x),
        .in_negate(bflip),
        .in_side({c1_side, c1_y, z2}),
        .out_valid(g_valid), .out_x(g_x), .out_side(g_side)
    );

    // ---- bearing rotation ----
    logic                 c2_valid;
    logic signed [DW-1:0] c2_x, c2_y;
    logic [S3W-1:0]       c2_side;

    s2c_cordic #(.DW(DW), .ZW(ZW), .NST(NST), .SW(S3W)) u_rot_bear (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(g_valid),
        .in_x(g_x),
        .in_y('0),
        .in_z($signed(g_side[ZW-1:0])),
        .in_side(g_side[S2W-1:ZW]),
        .out_valid(c2_valid), .out_x(c2_x), .out_y(c2_y), .out_side(c2_side)
    );

    // ---- output rounding and saturation ----
    function automatic logic [31:0] out_sat(input logic signed [DW-1:0] v);
        logic signed [DW:0] s;
        s = ($signed({v[DW-1], v}) + (DW+1)'(1 << (G - 1))) >>> G;
        if (s > OMAX)
            s = OMAX;
        else if (s < OMIN)
            s = OMIN;
        return s[31:0];
    endfunction

    logic              out_valid_reg;
    s2c_pkg::cart_beat_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= c2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.x_out         <= out_sat(c2_x);
            out_reg.y_out         <= out_sat(c2_y);
            out_reg.z_out         <= out_sat($signed(c2_side[DW-1:0]));
            out_reg.range_out     <= 31'(c2_side[S3W-1:DW+64]);
            out_reg.bearing_out   <= c2_side[DW+63:DW+32];
            out_reg.elevation_out <= c2_side[DW+31:DW];
        end
    end

    assign cart.valid = out_valid_reg;
    assign cart.data  = out_reg;

    // ---- assertions ----
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !polar.ready |-> cart.valid)
        else $error("input stalled while output stage empty");

    a_elev_folded: assert property (@(posedge clk) disable iff (!rst_n)
        cart.valid |-> (cart.data.elevation_out <= 32'sh40000000 &&
                        cart.data.elevation_out >= -32'sh40000000))
        else $error("elevation outside half turn");

    a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
        cart.valid && cart.data.range_out == 31'd0 |->
        cart.data.x_out == 32'sd0 && cart.data.y_out == 32'sd0 &&
        cart.data.z_out == 32'sd0)
        else $error("nonzero cartesian beat for zero range");

endmodule

// ===== design/s2c_cordic.sv =====
// unrolled rotation-mode cordic, one register stage per iteration
// depends on s2c_pkg for the arctangent table
module s2c_cordic #(
    parameter int DW = 42,
    parameter int ZW = 34,
    parameter int NST = 24,
    parameter int SW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] in_x,
    input  logic signed [DW-1:0] in_y,
    input  logic signed [ZW-1:0] in_z,
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    output logic signed [DW-1:0] out_x,
    output logic signed [DW-1:0] out_y,
    output logic [SW-1:0]        out_side
);

    logic                 v_reg [NST];
    logic signed [DW-1:0] x_reg [NST];
    logic signed [DW-1:0] y_reg [NST];
    logic signed [ZW-1:0] z_reg [NST];
    logic [SW-1:0]        s_reg [NST];

    for (genvar i = 0; i < NST; i++) begin : g_stage
        logic                 v_prev;
        logic signed [DW-1:0] x_prev, y_prev, x_next, y_next;
        logic signed [ZW-1:0] z_prev, z_next, ang;
        logic [SW-1:0]        s_prev;

        if (i == 0) begin : g_first
            assign v_prev = in_valid;
            assign x_prev = in_x;
            assign y_prev = in_y;
            assign z_prev = in_z;
            assign s_prev = in_side;
        end else begin : g_rest
            assign v_prev = v_reg[i-1];
            assign x_prev = x_reg[i-1];
            assign y_prev = y_reg[i-1];
            assign z_prev = z_reg[i-1];
            assign s_prev = s_reg[i-1];
        end

        assign ang = ZW'(s2c_pkg::atan_entry(6'(i)));

        // zero residual counts as positive
        always_comb
        begin
            if (!z_prev[ZW-1])
            begin
                x_next = x_prev - (y_prev >>> i);
                y_next = y_prev + (x_prev >>> i);
                z_next = z_prev - ang;
            end
            else
            begin
                x_next = x_prev + (y_prev >>> i);
                y_next = y_prev - (x_prev >>> i);
                z_next = z_prev + ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
                s_reg[i] <= s_prev;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_x     = x_reg[NST-1];
    assign out_y     = y_reg[NST-1];
    assign out_side  = s_reg[NST-1];

endmodule

// ===== design/s2c_gain.sv =====
// two-stage inverse cordic gain scaler, rounds half away from zero
// split into two partial products; depends on s2c_pkg
module s2c_gain #(
    parameter int DW = 42,
    parameter int SW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] in_x,
    input  logic                 in_negate,
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    output logic signed [DW-1:0] out_x,
    output logic [SW-1:0]        out_side
);

    localparam int LO = DW / 2;
    localparam int HW = DW - LO;
    localparam int SUMW = DW + 32;

    logic [DW-1:0]   mag;
    logic            a_valid_reg, a_sign_reg, b_valid_reg;
    logic [LO+30:0]  a_pl_reg;
    logic [HW+30:0]  a_ph_reg;
    logic [SW-1:0]   a_side_reg, b_side_reg;
    logic [SUMW-1:0] sum;
    logic [DW-1:0]   rnd;
    logic signed [DW-1:0] b_x_reg;

    assign mag = in_x[DW-1] ? DW'(-in_x) : DW'(in_x);
    assign sum = (SUMW'(a_ph_reg) << LO) + SUMW'(a_pl_reg) + (SUMW'(1) << 30);
    assign rnd = DW'(sum >> 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pl_reg   <= mag[LO-1:0] * s2c_pkg::INV_GAIN;
            a_ph_reg   <= mag[DW-1:LO] * s2c_pkg::INV_GAIN;
            a_sign_reg <= in_x[DW-1] ^ in_negate;
            a_side_reg <= in_side;
            b_x_reg    <= a_sign_reg ? -$signed(rnd) : $signed(rnd);
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_x     = b_x_reg;
    assign out_side  = b_side_reg;

endmodule
